// File: rtl/sfp_pkg.sv
// Shared types, constants and the byte-wide CRC-32 update for the frame parser.
`default_nettype none

package sfp_pkg;

   // Largest payload length that is accepted; longer frames are dropped.
   localparam logic [15:0] MAX_PAYLOAD    = 16'd1024;
   // Sync bytes, sequence, length and CRC add this much to the payload.
   localparam logic [31:0] FRAME_OVERHEAD = 32'd12;
   localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;

   localparam logic [7:0] SYNC_BYTE0 = 8'h55;
   localparam logic [7:0] SYNC_BYTE1 = 8'hAA;
   localparam logic [7:0] SYNC_BYTE2 = 8'hFF;
   localparam logic [7:0] SYNC_BYTE3 = 8'h00;

   typedef enum logic [3:0] {
      PH_SYNC0,
      PH_SYNC1,
      PH_SYNC2,
      PH_SYNC3,
      PH_SEQ0,
      PH_SEQ1,
      PH_LEN0,
      PH_LEN1,
      PH_DATA,
      PH_CRC0,
      PH_CRC1,
      PH_CRC2,
      PH_CRC3
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE,
      EV_GOOD,
      EV_BADCRC,
      EV_OVERSIZE,
      EV_SEQGAP
   } event_type;

   typedef struct packed {
      logic [31:0] total_byte_count;
      logic [31:0] sequence_error_count;
      logic [31:0] oversize_count;
      logic [31:0] bad_checksum_count;
      logic [31:0] good_frame_count;
      logic [31:0] good_byte_count;
   } stats_type;

   typedef struct packed {
      logic      frame_good;
      event_type event_code;
      stats_type stats;
   } rsp_type;

   // Reflected CRC-32 update by one byte, bit by bit over the low byte.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] t;
      t = {24'd0, crc[7:0] ^ b};
      for (int k = 0; k < 8; k++) begin
         if (t[0]) begin
            t = (t >> 1) ^ CRC_POLY;
         end else begin
            t = t >> 1;
         end
      end
      return {8'd0, crc[31:8]} ^ t;
   endfunction

endpackage

`default_nettype wire

// File: rtl/sync_frame_parser_crc32.sv
// Top level of the sync-framed byte stream parser with CRC-32 check and statistics.
`default_nettype none

// The block takes one line byte per item and hunts for frames of the form
// 55 AA FF 00, a little-endian 16-bit sequence number, a little-endian 16-bit
// payload length, the payload and a little-endian CRC-32 (reflected polynomial
// EDB88320, initial value zero, no final inversion) over everything before the
// CRC. Every accepted byte yields exactly one result item carrying the event of
// that byte (good frame, bad checksum, oversize length, sequence gap or none)
// and the six wrapping 32-bit statistics counters as they stand after it. A
// new byte can be accepted in every clock cycle while req_stall is low: the
// whole parse and the byte-wide CRC update sit between the state registers and
// the result register, so the result is registered at the edge that accepts its byte. The
// result register is backed by a one-item skid stage, so req_stall is a
// registered signal and rises only once two results are waiting; a sustained
// rate of one item per cycle holds whenever the consumer does not stall.
// Lengths above MAX_PAYLOAD abort the frame, and a wrong sync byte simply
// restarts the hunt without being retried as the first sync byte.
module sync_frame_parser_crc32
   import sfp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_frame_good,
   output logic [2:0]       rsp_event_code,
   output logic [31:0]      rsp_total_byte_count,
   output logic [31:0]      rsp_sequence_error_count,
   output logic [31:0]      rsp_oversize_count,
   output logic [31:0]      rsp_bad_checksum_count,
   output logic [31:0]      rsp_good_frame_count,
   output logic [31:0]      rsp_good_byte_count
);

   logic    item_en;
   rsp_type parse_rsp;
   rsp_type out_rsp;

   // An item enters the parser exactly when the handshake completes.
   assign item_en = req_valid && !req_stall;

   sfp_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .item_en  (item_en),
      .rx_byte  (req_rx_byte),
      .rsp_data (parse_rsp)
   );

   // The result of the accepted byte is captured at the same edge as the
   // parser state, in the output register or, if that is held, the skid stage.
   sfp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (item_en),
      .in_data   (parse_rsp),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_data  (out_rsp),
      .out_stall (rsp_stall)
   );

   assign rsp_frame_good           = out_rsp.frame_good;
   assign rsp_event_code           = out_rsp.event_code;
   assign rsp_total_byte_count     = out_rsp.stats.total_byte_count;
   assign rsp_sequence_error_count = out_rsp.stats.sequence_error_count;
   assign rsp_oversize_count       = out_rsp.stats.oversize_count;
   assign rsp_bad_checksum_count   = out_rsp.stats.bad_checksum_count;
   assign rsp_good_frame_count     = out_rsp.stats.good_frame_count;
   assign rsp_good_byte_count      = out_rsp.stats.good_byte_count;

endmodule

`default_nettype wire

// File: rtl/sfp_parser.sv
// Frame hunting state machine, running CRC and statistics counters.
`default_nettype none

module sfp_parser
   import sfp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       item_en,
   input  wire logic [7:0] rx_byte,
   output rsp_type         rsp_data
);

   phase_type   phase_ff, phase_in;
   logic [15:0] cur_seq_ff, cur_seq_in;
   logic [15:0] prev_seq_ff, prev_seq_in;
   logic [15:0] frame_len_ff, frame_len_in;
   logic [15:0] payload_cnt_ff, payload_cnt_in;
   logic [31:0] crc_ff, crc_in;
   logic [23:0] rx_crc_low_ff, rx_crc_low_in;
   stats_type   stats_ff, stats_in;

   logic [31:0] crc_step;
   logic [15:0] seq_full;
   logic [15:0] seq_diff;
   logic        seq_gap;
   logic [15:0] len_full;
   logic        oversize;
   logic [15:0] payload_inc;
   logic        payload_done;
   logic        crc_match;
   logic        frame_good;
   event_type   event_code;

   assign crc_step     = crc_byte(crc_ff, rx_byte);
   assign seq_full     = {rx_byte, cur_seq_ff[7:0]};
   assign seq_diff     = seq_full - prev_seq_ff;
   assign seq_gap      = (seq_diff != 16'd1);
   assign len_full     = {rx_byte, frame_len_ff[7:0]};
   assign oversize     = (len_full > MAX_PAYLOAD);
   assign payload_inc  = payload_cnt_ff + 16'd1;
   assign payload_done = (payload_inc == frame_len_ff);
   assign crc_match    = ({rx_byte, rx_crc_low_ff} == crc_ff);

   // Next phase.
   always_comb begin
      unique case (phase_ff)
         PH_SYNC0: phase_in = (rx_byte == SYNC_BYTE0) ? PH_SYNC1 : PH_SYNC0;
         PH_SYNC1: phase_in = (rx_byte == SYNC_BYTE1) ? PH_SYNC2 : PH_SYNC0;
         PH_SYNC2: phase_in = (rx_byte == SYNC_BYTE2) ? PH_SYNC3 : PH_SYNC0;
         PH_SYNC3: phase_in = (rx_byte == SYNC_BYTE3) ? PH_SEQ0  : PH_SYNC0;
         PH_SEQ0:  phase_in = PH_SEQ1;
         PH_SEQ1:  phase_in = PH_LEN0;
         PH_LEN0:  phase_in = PH_LEN1;
         PH_LEN1: begin
            if (oversize) begin
               phase_in = PH_SYNC0;
            end else if (len_full == 16'd0) begin
               phase_in = PH_CRC0;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA:  phase_in = payload_done ? PH_CRC0 : PH_DATA;
         PH_CRC0:  phase_in = PH_CRC1;
         PH_CRC1:  phase_in = PH_CRC2;
         PH_CRC2:  phase_in = PH_CRC3;
         PH_CRC3:  phase_in = PH_SYNC0;
         default:  phase_in = PH_SYNC0;
      endcase
   end

   // Datapath and result for the byte in hand.
   always_comb begin
      cur_seq_in     = cur_seq_ff;
      prev_seq_in    = prev_seq_ff;
      frame_len_in   = frame_len_ff;
      payload_cnt_in = payload_cnt_ff;
      crc_in         = crc_ff;
      rx_crc_low_in  = rx_crc_low_ff;
      stats_in       = stats_ff;
      frame_good     = 1'b0;
      event_code     = EV_NONE;

      stats_in.total_byte_count = stats_ff.total_byte_count + 32'd1;

      unique case (phase_ff) inside
         PH_SYNC0, PH_SYNC1, PH_SYNC2, PH_SYNC3: begin
            if (phase_in != PH_SYNC0) begin
               crc_in = crc_step;
            end else begin
               payload_cnt_in = 16'd0;
               crc_in         = 32'd0;
               rx_crc_low_in  = 24'd0;
            end
         end
         PH_SEQ0: begin
            crc_in     = crc_step;
            cur_seq_in = {8'd0, rx_byte};
         end
         PH_SEQ1: begin
            crc_in      = crc_step;
            cur_seq_in  = seq_full;
            prev_seq_in = seq_full;
            if (seq_gap) begin
               stats_in.sequence_error_count = stats_ff.sequence_error_count + 32'd1;
               event_code = EV_SEQGAP;
            end
         end
         PH_LEN0: begin
            crc_in       = crc_step;
            frame_len_in = {8'd0, rx_byte};
         end
         PH_LEN1: begin
            frame_len_in = len_full;
            if (oversize) begin
               stats_in.oversize_count = stats_ff.oversize_count + 32'd1;
               event_code     = EV_OVERSIZE;
               payload_cnt_in = 16'd0;
               crc_in         = 32'd0;
               rx_crc_low_in  = 24'd0;
            end else begin
               crc_in = crc_step;
            end
         end
         PH_DATA: begin
            crc_in         = crc_step;
            payload_cnt_in = payload_inc;
         end
         PH_CRC0: rx_crc_low_in = {16'd0, rx_byte};
         PH_CRC1: rx_crc_low_in = {8'd0, rx_byte, rx_crc_low_ff[7:0]};
         PH_CRC2: rx_crc_low_in = {rx_byte, rx_crc_low_ff[15:0]};
         PH_CRC3: begin
            if (crc_match) begin
               stats_in.good_frame_count = stats_ff.good_frame_count + 32'd1;
               stats_in.good_byte_count  = stats_ff.good_byte_count
                                         + {16'd0, frame_len_ff} + FRAME_OVERHEAD;
               event_code = EV_GOOD;
               frame_good = 1'b1;
            end else begin
               stats_in.bad_checksum_count = stats_ff.bad_checksum_count + 32'd1;
               event_code = EV_BADCRC;
            end
            payload_cnt_in = 16'd0;
            crc_in         = 32'd0;
            rx_crc_low_in  = 24'd0;
         end
         default: begin
            payload_cnt_in = 16'd0;
            crc_in         = 32'd0;
            rx_crc_low_in  = 24'd0;
         end
      endcase
   end

   assign rsp_data.frame_good = frame_good;
   assign rsp_data.event_code = event_code;
   assign rsp_data.stats      = stats_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SYNC0;
         cur_seq_ff     <= 16'd0;
         prev_seq_ff    <= 16'hFFFF;
         frame_len_ff   <= 16'd0;
         payload_cnt_ff <= 16'd0;
         crc_ff         <= 32'd0;
         rx_crc_low_ff  <= 24'd0;
         stats_ff       <= '0;
      end else if (item_en) begin
         phase_ff       <= phase_in;
         cur_seq_ff     <= cur_seq_in;
         prev_seq_ff    <= prev_seq_in;
         frame_len_ff   <= frame_len_in;
         payload_cnt_ff <= payload_cnt_in;
         crc_ff         <= crc_in;
         rx_crc_low_ff  <= rx_crc_low_in;
         stats_ff       <= stats_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/sfp_out_buf.sv
// Two-entry output register with a skid stage so that stall upstream is registered.
`default_nettype none

module sfp_out_buf
   import sfp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire rsp_type in_data,
   output logic         in_stall,
   output logic         out_valid,
   output rsp_type      out_data,
   input  wire logic    out_stall
);

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    accept;
   logic    out_free;

   assign in_stall  = skid_valid_ff;
   assign accept    = in_valid && !skid_valid_ff;
   assign out_free  = !out_valid_ff || !out_stall;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         out_valid_in  = skid_valid_ff || accept;
         out_data_in   = skid_valid_ff ? skid_data_ff : in_data;
         skid_valid_in = 1'b0;
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire

// File: rtl/sfp_checker.sv
// Port-level checks for the frame parser, bound to its top level.
`default_nettype none

module sfp_checker
   import sfp_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [7:0]  req_rx_byte,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_frame_good,
   input wire logic [2:0]  rsp_event_code,
   input wire logic [31:0] rsp_total_byte_count,
   input wire logic [31:0] rsp_sequence_error_count,
   input wire logic [31:0] rsp_oversize_count,
   input wire logic [31:0] rsp_bad_checksum_count,
   input wire logic [31:0] rsp_good_frame_count,
   input wire logic [31:0] rsp_good_byte_count
);

   // A held result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_total_byte_count)
         && $stable(rsp_event_code) && $stable(rsp_good_byte_count))
      else $error("stalled result changed");

   // The input only stalls when a result is already waiting.
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   // The good flag and the good-frame event always agree.
   a_good_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_good == (rsp_event_code == EV_GOOD)))
      else $error("frame_good disagrees with event_code");

   // A good-frame result carries the good-frame count after its increment, so that count is never zero.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_code == EV_GOOD) |-> rsp_good_frame_count != 32'd0)
      else $error("good frame reported with zero good count");

endmodule

bind sync_frame_parser_crc32 sfp_checker u_sfp_checker (.*);

`default_nettype wire
